// ----- rtl/bipartite_augmenting_path_matcher_assert.svh -----
// Assertion macros for the bipartite matcher
`ifndef BIPARTITE_AUGMENTING_PATH_MATCHER_ASSERT_SVH
`define BIPARTITE_AUGMENTING_PATH_MATCHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BAPM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BAPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bapm_pkg.sv -----
// Shared types and codes for the bipartite matcher
package bapm_pkg;

  localparam int FIELD_W = 9;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_EDGE  = 3'd1,
    OP_MATCH = 3'd2,
    OP_RUN   = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic RK_RUN  = 1'b0;
  localparam logic RK_READ = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [FIELD_W-1:0] row_index;
    logic [FIELD_W-1:0] column_index;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [FIELD_W-1:0] pairs_matched;
    logic               all_matched;
    logic [FIELD_W-1:0] owner_row;
  } out_item_t;

endpackage

// ----- rtl/bapm_if.sv -----
// Valid/ready stream interfaces for command beats and result beats
interface bapm_in_if import bapm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bapm_out_if import bapm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- rtl/bapm_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module bapm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bipartite_augmenting_path_matcher.sv -----
// Top level of the bipartite matcher: command decode, search sequencer and state memories
//
// Usage: command beats enter on in_ch (valid/ready), results leave on out_ch.
// Commands: clear graph, load edge, load initial match, run, read column.
// Only run and read produce a result beat; the others produce none.
// cfg_wr_en/cfg_wr_data set node_count (clamped to 1..MAX_NODES); the user must write
// them only while idle, as the block itself does not enforce this.
// Load edge writes the edge memory and fills row_first_edge for each row it advances
// last_row by (one write port); load initial match updates owner and partner in M1 and
// M2 (M1 only for row 0); read column reads the owner memory and registers the result.
// Clear graph and reset run a clearing pass over all MAX_NODES+1 entries of the
// owner and partner memories; in_ch.ready stays low during it.
// Run cleans up the owner memory, rebuilds the partner memory, then checks each row;
// an unmatched row adds a pass clearing the seen memory, then per visited row reads its
// span, scans its edges twice (edge memory then owner memory), backtracks when stuck and
// flips the found path row by row; the search walks one memory access at a time.
// One command is in work at a time; in_ch.ready is high only when idle.
// A finished result sits in the output register; a stalled receiver holds the
// block in its result state but an earlier result never blocks acceptance.
`include "bipartite_augmenting_path_matcher_assert.svh"

module bipartite_augmenting_path_matcher import bapm_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data,
  bapm_in_if.sink            in_ch,
  bapm_out_if.source         out_ch
);

  localparam int NW       = $clog2(MAX_NODES + 1);
  localparam int EW       = $clog2(MAX_EDGES + 1);
  localparam int EAW      = $clog2(MAX_EDGES);
  localparam int FAW      = $clog2(MAX_NODES + 2);
  localparam int CW       = FAW;
  localparam int NODE_RST = (MAX_NODES < 256) ? MAX_NODES : 256;

  typedef enum logic [23:0] {
    ST_CLR     = 24'b1 << 0,
    ST_IDLE    = 24'b1 << 1,
    ST_FILL    = 24'b1 << 2,
    ST_M1      = 24'b1 << 3,
    ST_M2      = 24'b1 << 4,
    ST_RDC     = 24'b1 << 5,
    ST_PA      = 24'b1 << 6,
    ST_PB      = 24'b1 << 7,
    ST_ROW_RD  = 24'b1 << 8,
    ST_ROW_CK  = 24'b1 << 9,
    ST_SPAN    = 24'b1 << 10,
    ST_SPAN_LO = 24'b1 << 11,
    ST_SPAN_HI = 24'b1 << 12,
    ST_S1_RD   = 24'b1 << 13,
    ST_S1_C    = 24'b1 << 14,
    ST_S1_O    = 24'b1 << 15,
    ST_S2_RD   = 24'b1 << 16,
    ST_S2_C    = 24'b1 << 17,
    ST_S2_O    = 24'b1 << 18,
    ST_BACK    = 24'b1 << 19,
    ST_FL_RD   = 24'b1 << 20,
    ST_FL_WR   = 24'b1 << 21,
    ST_DONE    = 24'b1 << 22,
    ST_SCLR    = 24'b1 << 23
  } state_t;

  state_t state;

  logic [CW-1:0]      cnt;
  logic [NW-1:0]      node_count;
  logic [EW-1:0]      edges_loaded;
  logic [NW-1:0]      last_row;
  logic [NW-1:0]      pair_count;
  logic [NW-1:0]      size;
  logic [NW-1:0]      row_i;
  logic [NW-1:0]      cur;
  logic [NW-1:0]      col_c;
  logic [EW-1:0]      k;
  logic [EW-1:0]      lo;
  logic [EW-1:0]      hi;
  logic [NW-1:0]      fill_row;
  logic [NW-1:0]      fill_end;
  logic [EW-1:0]      fill_val;
  logic [NW-1:0]      m_col;
  logic [NW-1:0]      m_row;
  logic [NW-1:0]      m_pr;
  logic               read_ok;
  logic               res_kind;
  logic [FIELD_W-1:0] res_row;
  logic               out_valid;
  out_item_t          out_item;

  logic           e_we;
  logic [EAW-1:0] e_waddr;
  logic [NW-1:0]  e_wdata;
  logic [EAW-1:0] e_raddr;
  logic [NW-1:0]  e_rdata;
  logic           f_we;
  logic [FAW-1:0] f_waddr;
  logic [EW-1:0]  f_wdata;
  logic [FAW-1:0] f_raddr;
  logic [EW-1:0]  f_rdata;
  logic           o_we;
  logic [NW-1:0]  o_waddr;
  logic [NW-1:0]  o_wdata;
  logic [NW-1:0]  o_raddr;
  logic [NW-1:0]  o_rdata;
  logic           p_we;
  logic [NW-1:0]  p_waddr;
  logic [NW-1:0]  p_wdata;
  logic [NW-1:0]  p_raddr;
  logic [NW-1:0]  p_rdata;
  logic           s_we;
  logic [NW-1:0]  s_waddr;
  logic [NW-1:0]  s_wdata;
  logic [NW-1:0]  s_raddr;
  logic [NW-1:0]  s_rdata;
  logic           v_we;
  logic [NW-1:0]  v_waddr;
  logic           v_wdata;
  logic [NW-1:0]  v_raddr;
  logic           v_rdata;

  logic          accept;
  logic          out_load;
  int            in_row_i;
  int            in_col_i;
  int            n_i;
  logic          col_ok;
  logic          edge_ok;
  logic          match_ok;
  logic          e_bad;
  logic          k_done;
  logic [NW-1:0] pa_prev;
  logic [NW-1:0] pa_fix;
  logic [NW-1:0] size_inc;
  logic [NW-1:0] cfg_clamped;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ch.ready);
  assign in_row_i = int'(in_ch.item.row_index);
  assign in_col_i = int'(in_ch.item.column_index);
  assign n_i      = int'(node_count);
  assign col_ok   = (in_col_i != 0) && (in_col_i <= MAX_NODES);
  assign edge_ok  = col_ok && (in_row_i != 0) && (in_row_i <= MAX_NODES) &&
                    (in_row_i >= int'(last_row)) && (int'(edges_loaded) < MAX_EDGES);
  assign match_ok = col_ok && (in_row_i <= MAX_NODES);
  assign e_bad    = (e_rdata == '0) || (int'(e_rdata) > n_i);
  assign k_done   = (k >= hi);
  assign pa_prev  = NW'(cnt - CW'(1));
  assign pa_fix   = ((int'(pa_prev) > n_i) || (int'(o_rdata) > n_i)) ? '0 : o_rdata;
  assign size_inc = size + NW'(1);

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_clamped = NW'(1);
    end else if (int'(cfg_wr_data) > MAX_NODES) begin
      cfg_clamped = NW'(MAX_NODES);
    end else begin
      cfg_clamped = NW'(cfg_wr_data);
    end
  end

  bapm_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  bapm_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 2)) u_first_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  bapm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_owner_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
  );

  bapm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_partner_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  bapm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_parent_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  bapm_ram #(.WIDTH(1), .DEPTH(MAX_NODES + 1)) u_seen_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );

  always_comb begin
    e_we    = 1'b0;
    e_waddr = edges_loaded[EAW-1:0];
    e_wdata = NW'(in_ch.item.column_index);
    e_raddr = k[EAW-1:0];
    f_we    = 1'b0;
    f_waddr = FAW'(fill_row);
    f_wdata = fill_val;
    f_raddr = FAW'(cur);
    o_we    = 1'b0;
    o_waddr = '0;
    o_wdata = '0;
    o_raddr = '0;
    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = cur;
    v_we    = 1'b0;
    v_waddr = col_c;
    v_wdata = 1'b1;
    v_raddr = e_rdata;
    unique case (state)
      ST_CLR: begin
        o_we    = 1'b1;
        o_waddr = NW'(cnt);
        p_we    = 1'b1;
        p_waddr = NW'(cnt);
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_ch.item.operation))
            OP_EDGE: begin
              e_we = edge_ok;
            end
            OP_MATCH: begin
              if (match_ok) begin
                o_raddr = NW'(in_ch.item.column_index);
                p_raddr = NW'(in_ch.item.row_index);
              end
            end
            OP_READ: begin
              if (col_ok) begin
                o_raddr = NW'(in_ch.item.column_index);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        f_we = 1'b1;
      end
      ST_M1: begin
        o_we    = 1'b1;
        o_waddr = m_col;
        o_wdata = m_row;
        if ((o_rdata != '0) && !((m_row != '0) && (o_rdata == m_row))) begin
          p_we    = 1'b1;
          p_waddr = o_rdata;
        end
      end
      ST_M2: begin
        if (m_pr != '0) begin
          o_we    = 1'b1;
          o_waddr = m_pr;
        end
        p_we    = 1'b1;
        p_waddr = m_row;
        p_wdata = m_col;
      end
      ST_PA: begin
        if (int'(cnt) <= MAX_NODES) begin
          p_we    = 1'b1;
          p_waddr = NW'(cnt);
          o_raddr = NW'(cnt);
        end
        if (cnt != '0) begin
          o_we    = 1'b1;
          o_waddr = pa_prev;
          o_wdata = pa_fix;
        end
      end
      ST_PB: begin
        if (int'(cnt) <= n_i) begin
          o_raddr = NW'(cnt);
        end
        if ((int'(cnt) >= 2) && (o_rdata != '0)) begin
          p_we    = 1'b1;
          p_waddr = o_rdata;
          p_wdata = pa_prev;
        end
      end
      ST_ROW_RD: begin
        p_raddr = row_i;
      end
      ST_ROW_CK: begin
        if (p_rdata == '0) begin
          s_we    = 1'b1;
          s_waddr = row_i;
        end
      end
      ST_SCLR: begin
        v_we    = 1'b1;
        v_waddr = NW'(cnt);
        v_wdata = 1'b0;
      end
      ST_SPAN_LO: begin
        f_raddr = FAW'(cur) + FAW'(1);
      end
      ST_S1_C: begin
        o_raddr = e_rdata;
      end
      ST_S2_C: begin
        o_raddr = e_rdata;
      end
      ST_S2_O: begin
        if ((o_rdata != '0) && !v_rdata) begin
          s_we    = 1'b1;
          s_waddr = o_rdata;
          s_wdata = cur;
          v_we    = 1'b1;
        end
      end
      ST_FL_RD: begin
        p_raddr = cur;
      end
      ST_FL_WR: begin
        o_we    = 1'b1;
        o_waddr = col_c;
        o_wdata = cur;
        p_we    = 1'b1;
        p_waddr = cur;
        p_wdata = col_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      cnt          <= '0;
      node_count   <= NW'(NODE_RST);
      edges_loaded <= '0;
      last_row     <= '0;
      pair_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_clamped;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          if (int'(cnt) == MAX_NODES) begin
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (op_t'(in_ch.item.operation))
              OP_CLEAR: begin
                edges_loaded <= '0;
                last_row     <= '0;
                pair_count   <= '0;
                cnt          <= '0;
                state        <= ST_CLR;
              end
              OP_EDGE: begin
                if (edge_ok) begin
                  edges_loaded <= edges_loaded + EW'(1);
                  if (in_row_i > int'(last_row)) begin
                    fill_row <= last_row + NW'(1);
                    fill_end <= NW'(in_ch.item.row_index);
                    fill_val <= edges_loaded;
                    last_row <= NW'(in_ch.item.row_index);
                    state    <= ST_FILL;
                  end
                end
              end
              OP_MATCH: begin
                if (match_ok) begin
                  m_col <= NW'(in_ch.item.column_index);
                  m_row <= NW'(in_ch.item.row_index);
                  state <= ST_M1;
                end
              end
              OP_RUN: begin
                cnt   <= '0;
                state <= ST_PA;
              end
              OP_READ: begin
                read_ok <= col_ok;
                state   <= ST_RDC;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL: begin
          if (fill_row == fill_end) begin
            state <= ST_IDLE;
          end else begin
            fill_row <= fill_row + NW'(1);
          end
        end
        ST_M1: begin
          m_pr  <= (o_rdata == m_row) ? '0 : p_rdata;
          state <= (m_row != '0) ? ST_M2 : ST_IDLE;
        end
        ST_M2: begin
          state <= ST_IDLE;
        end
        ST_RDC: begin
          res_kind <= RK_READ;
          res_row  <= read_ok ? FIELD_W'(o_rdata) : '0;
          state    <= ST_DONE;
        end
        ST_PA: begin
          if (int'(cnt) == MAX_NODES + 1) begin
            cnt   <= CW'(1);
            size  <= '0;
            state <= ST_PB;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_PB: begin
          if ((int'(cnt) >= 2) && (o_rdata != '0)) begin
            size <= size_inc;
          end
          if (int'(cnt) == n_i + 1) begin
            row_i <= NW'(1);
            state <= ST_ROW_RD;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_ROW_RD: begin
          state <= ST_ROW_CK;
        end
        ST_ROW_CK: begin
          if (p_rdata != '0) begin
            if (row_i == node_count) begin
              pair_count <= size;
              res_kind   <= RK_RUN;
              res_row    <= '0;
              state      <= ST_DONE;
            end else begin
              row_i <= row_i + NW'(1);
              state <= ST_ROW_RD;
            end
          end else begin
            cnt   <= '0;
            cur   <= row_i;
            state <= ST_SCLR;
          end
        end
        ST_SCLR: begin
          if (int'(cnt) == MAX_NODES) begin
            state <= ST_SPAN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_SPAN: begin
          if (cur > last_row) begin
            k     <= '0;
            lo    <= '0;
            hi    <= '0;
            state <= ST_S1_RD;
          end else begin
            state <= ST_SPAN_LO;
          end
        end
        ST_SPAN_LO: begin
          lo <= f_rdata;
          k  <= f_rdata;
          if (cur < last_row) begin
            state <= ST_SPAN_HI;
          end else begin
            hi    <= edges_loaded;
            state <= ST_S1_RD;
          end
        end
        ST_SPAN_HI: begin
          hi    <= f_rdata;
          state <= ST_S1_RD;
        end
        ST_S1_RD: begin
          if (k_done) begin
            k     <= lo;
            state <= ST_S2_RD;
          end else begin
            state <= ST_S1_C;
          end
        end
        ST_S1_C: begin
          if (e_bad) begin
            k     <= k + EW'(1);
            state <= ST_S1_RD;
          end else begin
            col_c <= e_rdata;
            state <= ST_S1_O;
          end
        end
        ST_S1_O: begin
          if (o_rdata == '0) begin
            state <= ST_FL_RD;
          end else begin
            k     <= k + EW'(1);
            state <= ST_S1_RD;
          end
        end
        ST_S2_RD: begin
          state <= k_done ? ST_BACK : ST_S2_C;
        end
        ST_S2_C: begin
          if (e_bad) begin
            k     <= k + EW'(1);
            state <= ST_S2_RD;
          end else begin
            col_c <= e_rdata;
            state <= ST_S2_O;
          end
        end
        ST_S2_O: begin
          if ((o_rdata != '0) && !v_rdata) begin
            cur   <= o_rdata;
            state <= ST_SPAN;
          end else begin
            k     <= k + EW'(1);
            state <= ST_S2_RD;
          end
        end
        ST_BACK: begin
          if (s_rdata == '0) begin
            pair_count <= size;
            res_kind   <= RK_RUN;
            res_row    <= '0;
            state      <= ST_DONE;
          end else begin
            cur   <= s_rdata;
            state <= ST_SPAN;
          end
        end
        ST_FL_RD: begin
          state <= ST_FL_WR;
        end
        ST_FL_WR: begin
          col_c <= p_rdata;
          cur   <= s_rdata;
          if (s_rdata == '0) begin
            size <= size_inc;
            if (row_i == node_count) begin
              pair_count <= size_inc;
              res_kind   <= RK_RUN;
              res_row    <= '0;
              state      <= ST_DONE;
            end else begin
              row_i <= row_i + NW'(1);
              state <= ST_ROW_RD;
            end
          end else begin
            state <= ST_FL_RD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_item.result_kind   <= res_kind;
            out_item.pairs_matched <= FIELD_W'(pair_count);
            out_item.all_matched   <= (pair_count == node_count);
            out_item.owner_row     <= res_row;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BAPM_ASSERT_IMPL(a_span_cur_nonzero, state == ST_SPAN, cur != '0, "search row is zero")
  `BAPM_ASSERT_IMPL(a_edges_bounded, 1'b1, int'(edges_loaded) <= MAX_EDGES, "edge count overflow")
  `BAPM_ASSERT_NEXT(a_result_held, state == ST_DONE && out_valid && !out_ch.ready, state == ST_DONE, "result dropped")
  `BAPM_ASSERT_IMPL(a_run_fits, state == ST_DONE && res_kind == RK_RUN, pair_count <= node_count, "match size exceeds nodes")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the bipartite augmenting-path matcher
`timescale 1ns / 100ps

module tb;
  import bapm_pkg::*;

  localparam int NODE_LIMIT   = 256;
  localparam int EDGE_LIMIT   = 4096;
  localparam int STALL_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [FIELD_W-1:0] cfg_wr_data;

  bapm_in_if  in_ch ();
  bapm_out_if out_ch ();

  bipartite_augmenting_path_matcher dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // matcher state mirror
  int unsigned edge_col [EDGE_LIMIT];
  int unsigned first_edge [NODE_LIMIT + 2];
  int unsigned col_owner [NODE_LIMIT + 1];
  int unsigned row_mate [NODE_LIMIT + 1];
  int unsigned dfs_parent [NODE_LIMIT + 1];
  bit          col_visited [NODE_LIMIT + 1];
  int unsigned edge_count;
  int unsigned top_row;
  int unsigned pair_total;
  int unsigned nodes;

  out_item_t pending_results [$];
  int        fail_count;
  int        idle_cycles;
  int        out_hold;
  bit        quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void row_edges(int unsigned r, output int unsigned lo,
                                    output int unsigned hi);
    if (r == 0 || r > top_row) begin
      lo = 0;
      hi = 0;
    end else begin
      lo = first_edge[r];
      hi = (r < top_row) ? first_edge[r + 1] : edge_count;
    end
  endfunction

  function automatic void augment_all();
    int unsigned n, c, i, cur, fin, lo, hi, k, prev, size;
    bit went;
    n = nodes;
    size = 0;
    for (c = 1; c <= NODE_LIMIT; c++)
      if (c > n || col_owner[c] > n) col_owner[c] = 0;
    for (c = 0; c <= NODE_LIMIT; c++) row_mate[c] = 0;
    for (c = 1; c <= n; c++)
      if (col_owner[c] != 0) begin
        row_mate[col_owner[c]] = c;
        size++;
      end
    for (i = 1; i <= n; i++) begin
      if (row_mate[i] != 0) continue;
      cur = i;
      fin = 0;
      dfs_parent[i] = 0;
      for (c = 0; c <= NODE_LIMIT; c++) col_visited[c] = 1'b0;
      while (cur != 0 && fin == 0) begin
        went = 1'b0;
        row_edges(cur, lo, hi);
        for (k = lo; k < hi && k < EDGE_LIMIT; k++) begin
          c = edge_col[k];
          if (c == 0 || c > n) continue;
          if (col_owner[c] == 0) begin
            fin = c;
            break;
          end
        end
        if (fin != 0) break;
        for (k = lo; k < hi && k < EDGE_LIMIT; k++) begin
          c = edge_col[k];
          if (c == 0 || c > n) continue;
          if (!col_visited[c] && col_owner[c] != 0) begin
            dfs_parent[col_owner[c]] = cur;
            col_visited[c] = 1'b1;
            cur = col_owner[c];
            went = 1'b1;
            break;
          end
        end
        if (!went) cur = dfs_parent[cur];
      end
      if (cur == 0) break;
      c = fin;
      while (cur != 0) begin
        prev = row_mate[cur];
        col_owner[c] = cur;
        row_mate[cur] = c;
        c = prev;
        cur = dfs_parent[cur];
      end
      size++;
    end
    pair_total = size & 9'h1FF;
  endfunction

  function automatic void predict_cmd(in_item_t it);
    int unsigned r, c, old;
    out_item_t res;
    r = 32'(it.row_index);
    c = 32'(it.column_index);
    res = '0;
    case (it.operation)
      OP_CLEAR: begin
        edge_count = 0;
        top_row = 0;
        pair_total = 0;
        for (int j = 0; j <= NODE_LIMIT; j++) begin
          col_owner[j] = 0;
          row_mate[j] = 0;
        end
      end
      OP_EDGE: begin
        if (r != 0 && r <= NODE_LIMIT && r >= top_row && c != 0 && c <= NODE_LIMIT
            && edge_count < EDGE_LIMIT) begin
          while (top_row < r) begin
            top_row++;
            first_edge[top_row] = edge_count;
          end
          edge_col[edge_count] = c;
          edge_count++;
        end
      end
      OP_MATCH: begin
        if (c != 0 && c <= NODE_LIMIT && r <= NODE_LIMIT) begin
          old = col_owner[c];
          if (old != 0) row_mate[old] = 0;
          col_owner[c] = 0;
          if (r != 0) begin
            if (row_mate[r] != 0) col_owner[row_mate[r]] = 0;
            col_owner[c] = r;
            row_mate[r] = c;
          end
        end
      end
      OP_RUN: begin
        augment_all();
        res.result_kind   = RK_RUN;
        res.pairs_matched = FIELD_W'(pair_total);
        res.all_matched   = (pair_total == nodes);
        pending_results.push_back(res);
      end
      OP_READ: begin
        res.result_kind   = RK_READ;
        res.pairs_matched = FIELD_W'(pair_total);
        res.all_matched   = (pair_total == nodes);
        res.owner_row     = FIELD_W'((c != 0 && c <= NODE_LIMIT) ? col_owner[c] : 0);
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(logic [2:0] op, int unsigned r, int unsigned c);
    int gap;
    in_item_t it;
    gap = quiet ? 0 : $urandom_range(0, 18);
    it.operation    = op;
    it.row_index    = r[FIELD_W-1:0];
    it.column_index = c[FIELD_W-1:0];
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_cmd(it);
  endtask

  // drain results and let the block return to idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_nodes(int unsigned v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[FIELD_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    nodes = (v == 0) ? 1 : (v > NODE_LIMIT) ? NODE_LIMIT : v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          out_item_t want;
          want = pending_results.pop_front();
          if (out_ch.item.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_ch.item.result_kind);
            fail_count++;
          end
          if (out_ch.item.pairs_matched !== want.pairs_matched) begin
            $error("pairs_matched: expected %0d, got %0d", want.pairs_matched,
                   out_ch.item.pairs_matched);
            fail_count++;
          end
          if (out_ch.item.all_matched !== want.all_matched) begin
            $error("all_matched: expected %0d, got %0d", want.all_matched,
                   out_ch.item.all_matched);
            fail_count++;
          end
          if (out_ch.item.owner_row !== want.owner_row) begin
            $error("owner_row: expected %0d, got %0d", want.owner_row,
                   out_ch.item.owner_row);
            fail_count++;
          end
        end
        out_hold = quiet ? 0 : $urandom_range(0, 18);
      end
      if (out_hold > 0) begin
        out_ch.ready <= 1'b0;
        out_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_graph();
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_READ, 0, 256);
    send_cmd(OP_READ, 511, 511);
    send_cmd(OP_RUN, 0, 0);
  endtask

  task automatic test_node_count_clamp();
    write_nodes(0);
    send_cmd(OP_CLEAR, 0, 0);
    send_cmd(OP_EDGE, 1, 1);
    send_cmd(OP_RUN, 0, 0);
    write_nodes(511);
    send_cmd(OP_RUN, 0, 0);
    write_nodes(256);
  endtask

  task automatic test_augmenting_paths();
    write_nodes(3);
    send_cmd(OP_CLEAR, 0, 0);
    send_cmd(OP_EDGE, 1, 1);
    send_cmd(OP_EDGE, 1, 2);
    send_cmd(OP_EDGE, 0, 3);
    send_cmd(OP_EDGE, 257, 3);
    send_cmd(OP_EDGE, 2, 0);
    send_cmd(OP_EDGE, 3, 1);
    send_cmd(OP_EDGE, 2, 3);
    send_cmd(OP_RUN, 0, 0);
    send_cmd(OP_READ, 0, 2);
    send_cmd(OP_READ, 0, 3);
  endtask

  task automatic test_match_loading();
    send_cmd(OP_MATCH, 1, 3);
    send_cmd(OP_MATCH, 2, 3);
    send_cmd(OP_MATCH, 2, 1);
    send_cmd(OP_MATCH, 0, 1);
    send_cmd(OP_MATCH, 1, 0);
    send_cmd(OP_MATCH, 257, 2);
    send_cmd(OP_MATCH, 3, 300);
    send_cmd(OP_READ, 0, 3);
    send_cmd(OP_RUN, 0, 0);
    send_cmd(OP_READ, 0, 1);
  endtask

  task automatic test_stale_state();
    send_cmd(OP_MATCH, 3, 2);
    write_nodes(2);
    send_cmd(OP_RUN, 0, 0);
    send_cmd(OP_READ, 0, 3);
    send_cmd(OP_SPARE_5, 1, 1);
    send_cmd(OP_SPARE_6, 2, 2);
    send_cmd(OP_SPARE_7, 511, 511);
    send_cmd(OP_READ, 0, 2);
  endtask

  task automatic test_random_phases();
    int unsigned n, rows, span, sent, row;
    sent = 0;
    while (sent < 1110) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = 256;
        default: n = $urandom_range(2, 12);
      endcase
      write_nodes(n);
      send_cmd(OP_CLEAR, 0, 0);
      sent++;
      span = (n > 12) ? 16 : n + 2;
      rows = $urandom_range(1, span);
      row = 1;
      while (row <= rows) begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 19) == 0)
            send_cmd(OP_EDGE, $urandom_range(0, 511), $urandom_range(0, 511));
          else
            send_cmd(OP_EDGE, row, $urandom_range(1, (n > 12) ? 20 : n + 1));
          sent++;
        end
        row += ($urandom_range(0, 5) == 0) ? 2 : 1;
      end
      repeat ($urandom_range(0, 3)) begin
        send_cmd(OP_MATCH, $urandom_range(0, n + 1), $urandom_range(1, span));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(3'($urandom_range(2, 7)), $urandom_range(0, 511), $urandom_range(0, 511));
        sent++;
      end
      send_cmd(OP_RUN, 0, 0);
      sent++;
      repeat ($urandom_range(1, 4)) begin
        send_cmd(OP_READ, 0, $urandom_range(0, span));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        send_cmd(OP_MATCH, $urandom_range(0, n), $urandom_range(1, span));
        send_cmd(OP_RUN, 0, 0);
        send_cmd(OP_READ, 0, $urandom_range(1, span));
        sent += 3;
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.item  <= '0;
    fail_count = 0;
    quiet = 1'b0;
    edge_count = 0;
    top_row = 0;
    pair_total = 0;
    nodes = NODE_LIMIT;
    for (int j = 0; j <= NODE_LIMIT; j++) begin
      col_owner[j] = 0;
      row_mate[j] = 0;
      dfs_parent[j] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    settle();

    test_empty_graph();
    test_node_count_clamp();
    test_augmenting_paths();
    test_match_loading();
    test_stale_state();
    test_random_phases();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
